// File: rtl/core/rcarm_pkg.sv
// shared types, constants and reset values for the arming and calibration supervisor
package rcarm_pkg;

	localparam int unsigned PULSE_W     = 12;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned INTERVAL_W  = 10;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 12;

	// sample sums are kept pre-scaled by a reciprocal of the sample count
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W     = 25;
	localparam int unsigned SCALED_W    = PULSE_W + RECIP_W;
	localparam int unsigned ACC_W       = SCALED_W + COUNT_W;

	localparam int unsigned CAL_SAMPLES_DEF = 50;

	localparam logic [INTERVAL_W-1:0] RST_INTERVAL    = 10'd20;
	localparam logic [PULSE_W-1:0]    RST_JITTER      = 12'd30;
	localparam logic [PULSE_W-1:0]    RST_CENTER_MIN  = 12'd1430;
	localparam logic [PULSE_W-1:0]    RST_CENTER_MAX  = 12'd1570;
	localparam logic [PULSE_W-1:0]    RST_BOTTOM_MIN  = 12'd970;
	localparam logic [PULSE_W-1:0]    RST_BOTTOM_MAX  = 12'd1100;
	localparam logic [PULSE_W-1:0]    RST_SWITCH_LOW  = 12'd1300;
	localparam logic [PULSE_W-1:0]    RST_SWITCH_HIGH = 12'd1700;

	localparam logic [PULSE_W-1:0] LOWEST_INIT  = 12'd2000;
	localparam logic [PULSE_W-1:0] HIGHEST_INIT = 12'd1000;
	localparam logic [PULSE_W-1:0] STEER_CENTER_RST    = 12'd1500;
	localparam logic [PULSE_W-1:0] THROTTLE_CENTER_RST = 12'd1000;

	typedef enum logic [1:0] {
		PH_WAITING     = 2'd0,
		PH_CALIBRATING = 2'd1,
		PH_READY       = 2'd2,
		PH_ERROR       = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MODE_HAND      = 2'd0,
		MODE_DIRECT    = 2'd1,
		MODE_BACKTRACE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		DIR_IDLE  = 2'd0,
		DIR_AHEAD = 2'd1,
		DIR_BACK  = 2'd2
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_INTERVAL = 3'd0,
		CFG_JITTER_LIMIT    = 3'd1,
		CFG_CENTER_MIN      = 3'd2,
		CFG_CENTER_MAX      = 3'd3,
		CFG_BOTTOM_MIN      = 3'd4,
		CFG_BOTTOM_MAX      = 3'd5,
		CFG_SWITCH_LOW      = 3'd6,
		CFG_SWITCH_HIGH     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] sample_gap;
		logic [PULSE_W-1:0]    jitter_limit;
		logic [PULSE_W-1:0]    center_min;
		logic [PULSE_W-1:0]    center_max;
		logic [PULSE_W-1:0]    bottom_min;
		logic [PULSE_W-1:0]    bottom_max;
		logic [PULSE_W-1:0]    switch_low;
		logic [PULSE_W-1:0]    switch_high;
	} cfg_t;

	typedef struct packed {
		logic                 link_up;
		logic                 frame_fresh;
		logic [TIME_W-1:0]    time_ms;
		logic [PULSE_W-1:0]   steering_pulse;
		logic [PULSE_W-1:0]   throttle_pulse;
		logic [PULSE_W-1:0]   direction_pulse;
		logic [PULSE_W-1:0]   home_pulse;
		logic [SCALED_W-1:0]  steer_scaled;
		logic [SCALED_W-1:0]  throttle_scaled;
	} item_t;

endpackage

// File: rtl/core/rc_arming_calibration_fsm.sv
// top level of the arming and calibration supervisor
// One transaction is accepted per clock while item_stall is low, and each produces one result:
// the item is registered in the input register on acceptance, and the updated state is
// registered as the result when the item advances. The state update loop (timestamp compare,
// accumulate, min/max, window checks) is combinational between the state registers, so the
// sustained rate is one item per clock unless the result stalls; a stalled result holds the
// input register, and a new item is still taken while the result waits if the register is free.
// The average over the calibration samples comes from sums kept pre-scaled by a constant
// reciprocal, so no divider is present. Configuration registers reset to their defaults.
module rc_arming_calibration_fsm #(
	parameter int unsigned CALIBRATION_SAMPLES = rcarm_pkg::CAL_SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcarm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcarm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             link_up,
	input  logic                             frame_fresh,
	input  logic [rcarm_pkg::TIME_W-1:0]     time_ms,
	input  logic [rcarm_pkg::PULSE_W-1:0]    steering_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]    throttle_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]    direction_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]    home_pulse,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [1:0]                       vehicle_state,
	output logic [1:0]                       drive_mode,
	output logic [1:0]                       drive_direction,
	output logic [rcarm_pkg::PULSE_W-1:0]    steering_center,
	output logic [rcarm_pkg::PULSE_W-1:0]    throttle_center
);
	import rcarm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  out_free;

	rcarm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rcarm_in_stage #(
		.CALIBRATION_SAMPLES (CALIBRATION_SAMPLES)
	) u_in (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.link_up         (link_up),
		.frame_fresh     (frame_fresh),
		.time_ms         (time_ms),
		.steering_pulse  (steering_pulse),
		.throttle_pulse  (throttle_pulse),
		.direction_pulse (direction_pulse),
		.home_pulse      (home_pulse),
		.out_free        (out_free),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	rcarm_core #(
		.CALIBRATION_SAMPLES (CALIBRATION_SAMPLES)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1),
		.out_free        (out_free),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.vehicle_state   (vehicle_state),
		.drive_mode      (drive_mode),
		.drive_direction (drive_direction),
		.steering_center (steering_center),
		.throttle_center (throttle_center)
	);

endmodule

// File: rtl/core/rcarm_cfg_regs.sv
// configuration register file with reset defaults
module rcarm_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcarm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcarm_pkg::CFG_DATA_W-1:0] cfg_data,
	output rcarm_pkg::cfg_t                  cfg
);
	import rcarm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_gap   <= RST_INTERVAL;
			cfg_q.jitter_limit <= RST_JITTER;
			cfg_q.center_min   <= RST_CENTER_MIN;
			cfg_q.center_max   <= RST_CENTER_MAX;
			cfg_q.bottom_min   <= RST_BOTTOM_MIN;
			cfg_q.bottom_max   <= RST_BOTTOM_MAX;
			cfg_q.switch_low   <= RST_SWITCH_LOW;
			cfg_q.switch_high  <= RST_SWITCH_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAMPLE_INTERVAL: cfg_q.sample_gap   <= cfg_data[INTERVAL_W-1:0];
				CFG_JITTER_LIMIT:    cfg_q.jitter_limit <= cfg_data[PULSE_W-1:0];
				CFG_CENTER_MIN:      cfg_q.center_min   <= cfg_data[PULSE_W-1:0];
				CFG_CENTER_MAX:      cfg_q.center_max   <= cfg_data[PULSE_W-1:0];
				CFG_BOTTOM_MIN:      cfg_q.bottom_min   <= cfg_data[PULSE_W-1:0];
				CFG_BOTTOM_MAX:      cfg_q.bottom_max   <= cfg_data[PULSE_W-1:0];
				CFG_SWITCH_LOW:      cfg_q.switch_low   <= cfg_data[PULSE_W-1:0];
				CFG_SWITCH_HIGH:     cfg_q.switch_high  <= cfg_data[PULSE_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/rcarm_in_stage.sv
// input register stage, pre-scales the stick samples by the reciprocal of the sample count
module rcarm_in_stage #(
	parameter int unsigned CALIBRATION_SAMPLES = rcarm_pkg::CAL_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                link_up,
	input  logic                                frame_fresh,
	input  logic [rcarm_pkg::TIME_W-1:0]        time_ms,
	input  logic [rcarm_pkg::PULSE_W-1:0]       steering_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]       throttle_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]       direction_pulse,
	input  logic [rcarm_pkg::PULSE_W-1:0]       home_pulse,
	input  logic                                out_free,
	output logic                                valid_s1,
	output rcarm_pkg::item_t                    item_s1
);
	import rcarm_pkg::*;

	// floor(2^shift / n) + 1 gives an exact quotient for every sum of up to 63 samples
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(CALIBRATION_SAMPLES) + 64'd1);

	logic load;
	logic advance;

	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign load       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.link_up         <= link_up;
			item_s1.frame_fresh     <= frame_fresh;
			item_s1.time_ms         <= time_ms;
			item_s1.steering_pulse  <= steering_pulse;
			item_s1.throttle_pulse  <= throttle_pulse;
			item_s1.direction_pulse <= direction_pulse;
			item_s1.home_pulse      <= home_pulse;
			item_s1.steer_scaled    <= SCALED_W'(steering_pulse) * SCALED_W'(RECIP);
			item_s1.throttle_scaled <= SCALED_W'(throttle_pulse) * SCALED_W'(RECIP);
		end
	end

endmodule

// File: rtl/core/rcarm_core.sv
// supervisor state machine, calibration accumulators and result register
module rcarm_core #(
	parameter int unsigned CALIBRATION_SAMPLES = rcarm_pkg::CAL_SAMPLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rcarm_pkg::cfg_t                cfg,
	input  logic                           valid_s1,
	input  rcarm_pkg::item_t               item_s1,
	output logic                           out_free,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     vehicle_state,
	output logic [1:0]                     drive_mode,
	output logic [1:0]                     drive_direction,
	output logic [rcarm_pkg::PULSE_W-1:0]  steering_center,
	output logic [rcarm_pkg::PULSE_W-1:0]  throttle_center
);
	import rcarm_pkg::*;

	localparam logic [COUNT_W-1:0] NUM_SAMPLES = COUNT_W'(CALIBRATION_SAMPLES);

	function automatic logic in_window(logic [PULSE_W-1:0] v, logic [PULSE_W-1:0] lo,
			logic [PULSE_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	phase_t              phase_q, phase_d;
	mode_t               mode_q, mode_d;
	dir_t                dir_q, dir_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [ACC_W-1:0]    steer_acc_q, steer_acc_d;
	logic [ACC_W-1:0]    thr_acc_q, thr_acc_d;
	logic [PULSE_W-1:0]  steer_lo_q, steer_lo_d, steer_hi_q, steer_hi_d;
	logic [PULSE_W-1:0]  thr_lo_q, thr_lo_d, thr_hi_q, thr_hi_d;
	logic [TIME_W-1:0]   last_ms_q, last_ms_d;
	logic [PULSE_W-1:0]  steer_ctr_q, steer_ctr_d, thr_ctr_q, thr_ctr_d;
	logic                result_valid_q;

	logic                advance;
	logic [TIME_W-1:0]   elapsed;
	logic [ACC_W-1:0]    steer_acc_new, thr_acc_new;
	logic [PULSE_W-1:0]  steer_lo_new, steer_hi_new, thr_lo_new, thr_hi_new;
	logic [COUNT_W-1:0]  count_new;
	logic [PULSE_W-1:0]  steer_avg, thr_avg;
	logic signed [PULSE_W:0] steer_spread, thr_spread, jitter_s;
	logic                stable, cal_ok;

	assign out_free = !result_valid_q || !result_stall;
	assign advance  = valid_s1 && out_free;

	always_comb begin
		elapsed       = item_s1.time_ms - last_ms_q;
		steer_acc_new = steer_acc_q + ACC_W'(item_s1.steer_scaled);
		thr_acc_new   = thr_acc_q + ACC_W'(item_s1.throttle_scaled);
		steer_lo_new  = (item_s1.steering_pulse < steer_lo_q) ? item_s1.steering_pulse : steer_lo_q;
		steer_hi_new  = (item_s1.steering_pulse > steer_hi_q) ? item_s1.steering_pulse : steer_hi_q;
		thr_lo_new    = (item_s1.throttle_pulse < thr_lo_q) ? item_s1.throttle_pulse : thr_lo_q;
		thr_hi_new    = (item_s1.throttle_pulse > thr_hi_q) ? item_s1.throttle_pulse : thr_hi_q;
		count_new     = count_q + COUNT_W'(1);
		steer_avg     = steer_acc_new[RECIP_SHIFT +: PULSE_W];
		thr_avg       = thr_acc_new[RECIP_SHIFT +: PULSE_W];
		steer_spread  = $signed({1'b0, steer_hi_new}) - $signed({1'b0, steer_lo_new});
		thr_spread    = $signed({1'b0, thr_hi_new}) - $signed({1'b0, thr_lo_new});
		jitter_s      = $signed({1'b0, cfg.jitter_limit});
		stable        = (steer_spread < jitter_s) && (thr_spread < jitter_s);
		cal_ok        = stable && in_window(steer_avg, cfg.center_min, cfg.center_max) &&
			in_window(thr_avg, cfg.bottom_min, cfg.bottom_max);

		phase_d     = phase_q;
		mode_d      = mode_q;
		dir_d       = dir_q;
		count_d     = count_q;
		steer_acc_d = steer_acc_q;
		thr_acc_d   = thr_acc_q;
		steer_lo_d  = steer_lo_q;
		steer_hi_d  = steer_hi_q;
		thr_lo_d    = thr_lo_q;
		thr_hi_d    = thr_hi_q;
		last_ms_d   = last_ms_q;
		steer_ctr_d = steer_ctr_q;
		thr_ctr_d   = thr_ctr_q;

		if (!item_s1.link_up) begin
			phase_d = PH_WAITING;
			mode_d  = MODE_HAND;
			dir_d   = DIR_IDLE;
			count_d = '0;
		end else begin
			unique case (phase_q)
				PH_WAITING: begin
					phase_d     = PH_CALIBRATING;
					count_d     = '0;
					steer_acc_d = '0;
					thr_acc_d   = '0;
					steer_lo_d  = LOWEST_INIT;
					thr_lo_d    = LOWEST_INIT;
					steer_hi_d  = HIGHEST_INIT;
					thr_hi_d    = HIGHEST_INIT;
					last_ms_d   = item_s1.time_ms;
				end
				PH_CALIBRATING: begin
					if (elapsed >= TIME_W'(cfg.sample_gap)) begin
						last_ms_d   = item_s1.time_ms;
						steer_acc_d = steer_acc_new;
						thr_acc_d   = thr_acc_new;
						steer_lo_d  = steer_lo_new;
						steer_hi_d  = steer_hi_new;
						thr_lo_d    = thr_lo_new;
						thr_hi_d    = thr_hi_new;
						count_d     = count_new;
						if (count_new >= NUM_SAMPLES) begin
							if (cal_ok) begin
								steer_ctr_d = steer_avg;
								thr_ctr_d   = thr_avg;
								phase_d     = PH_READY;
							end else begin
								phase_d = PH_ERROR;
							end
						end
					end
				end
				PH_ERROR: begin
					if (in_window(item_s1.steering_pulse, cfg.center_min, cfg.center_max) &&
						in_window(item_s1.throttle_pulse, cfg.bottom_min, cfg.bottom_max)) begin
						phase_d = PH_WAITING;
					end
				end
				PH_READY: begin
					if (item_s1.frame_fresh) begin
						priority if (item_s1.direction_pulse > cfg.switch_high) begin
							dir_d = DIR_AHEAD;
						end else if (item_s1.direction_pulse < cfg.switch_low) begin
							dir_d = DIR_BACK;
						end else begin
							dir_d = DIR_IDLE;
						end
						priority if (item_s1.home_pulse < cfg.switch_low) begin
							mode_d = MODE_HAND;
						end else if (item_s1.home_pulse <= cfg.switch_high) begin
							mode_d = MODE_DIRECT;
						end else begin
							mode_d = MODE_BACKTRACE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAITING;
			mode_q      <= MODE_HAND;
			dir_q       <= DIR_IDLE;
			count_q     <= '0;
			steer_acc_q <= '0;
			thr_acc_q   <= '0;
			steer_lo_q  <= LOWEST_INIT;
			steer_hi_q  <= HIGHEST_INIT;
			thr_lo_q    <= LOWEST_INIT;
			thr_hi_q    <= HIGHEST_INIT;
			last_ms_q   <= '0;
			steer_ctr_q <= STEER_CENTER_RST;
			thr_ctr_q   <= THROTTLE_CENTER_RST;
		end else if (advance) begin
			phase_q     <= phase_d;
			mode_q      <= mode_d;
			dir_q       <= dir_d;
			count_q     <= count_d;
			steer_acc_q <= steer_acc_d;
			thr_acc_q   <= thr_acc_d;
			steer_lo_q  <= steer_lo_d;
			steer_hi_q  <= steer_hi_d;
			thr_lo_q    <= thr_lo_d;
			thr_hi_q    <= thr_hi_d;
			last_ms_q   <= last_ms_d;
			steer_ctr_q <= steer_ctr_d;
			thr_ctr_q   <= thr_ctr_d;
		end
	end

	// result transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid    = result_valid_q;
	assign vehicle_state   = phase_q;
	assign drive_mode      = mode_q;
	assign drive_direction = dir_q;
	assign steering_center = steer_ctr_q;
	assign throttle_center = thr_ctr_q;

endmodule
